// File: design/cbq_pkg.sv
// Shared types, widths, constants and the microcode program for the biquad cascade.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package cbq_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int STATE_W  = 48;
  localparam int COEF_W   = 18;
  localparam int GAIN_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 5;
  localparam int REGIDX_W = 3;

  // Datapath widths
  localparam int HALF_W    = STATE_W / 2;
  localparam int HI_W      = STATE_W - HALF_W;
  localparam int A_W       = HI_W + 1;
  localparam int B_W       = GAIN_W + 1;
  localparam int P_W       = A_W + B_W;
  localparam int ACC_W     = STATE_W + GAIN_W + 2;
  localparam int N1_W      = SAMPLE_W + 2;
  localparam int N2_W      = STATE_W + 2;
  localparam int OUT_SHIFT = FRAC_W + GAIN_W;

  // Rounding offsets: half an LSB of the value kept after the shift
  localparam logic [ACC_W-1:0] STAGE_RND = ACC_W'(1) << (FRAC_W - 1);
  localparam logic [ACC_W-1:0] OUT_RND   = ACC_W'(1) << (OUT_SHIFT - 1);

  localparam logic [STATE_W-1:0]  STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic [STATE_W-1:0]  STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};
  localparam logic [SAMPLE_W-1:0] OUT_MAX   = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] OUT_MIN   = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Register reset values
  localparam logic [COEF_W-1:0] S1_FB1_RST = COEF_W'(112008);
  localparam logic [COEF_W-1:0] S1_FB2_RST = COEF_W'(-51957);
  localparam logic [COEF_W-1:0] S2_FB1_RST = COEF_W'(97693);
  localparam logic [COEF_W-1:0] S2_FB2_RST = COEF_W'(-36943);
  localparam logic [GAIN_W-1:0] GAIN_RST   = GAIN_W'(1640768);

  typedef enum logic [REGIDX_W-1:0] {
    REG_S1_FB1 = 3'd0,
    REG_S1_FB2 = 3'd1,
    REG_S2_FB1 = 3'd2,
    REG_S2_FB2 = 3'd3,
    REG_GAIN   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [COEF_W-1:0] s1_fb1;
    logic [COEF_W-1:0] s1_fb2;
    logic [COEF_W-1:0] s2_fb1;
    logic [COEF_W-1:0] s2_fb2;
    logic [GAIN_W-1:0] gain;
  } coef_t;

  // Microcode fields
  localparam int STEP_W    = 4;
  localparam int LAST_STEP = 14;

  typedef enum logic [1:0] {
    HOLD_NONE = 2'd0,
    HOLD_IN   = 2'd1,
    HOLD_OUT  = 2'd2
  } hold_e;

  typedef enum logic [1:0] {
    A_M1 = 2'd0,
    A_M2 = 2'd1,
    A_O1 = 2'd2,
    A_O2 = 2'd3
  } asel_e;

  typedef enum logic [2:0] {
    B_S1_FB1 = 3'd0,
    B_S1_FB2 = 3'd1,
    B_S2_FB1 = 3'd2,
    B_S2_FB2 = 3'd3,
    B_GAIN   = 3'd4
  } bsel_e;

  typedef enum logic [2:0] {
    ACC_HOLD  = 3'd0,
    ACC_LOAD1 = 3'd1,
    ACC_LOAD2 = 3'd2,
    ACC_LOADR = 3'd3,
    ACC_ADD   = 3'd4
  } accop_e;

  typedef struct packed {
    hold_e             hold_on;
    logic              jump;
    logic [STEP_W-1:0] target;
    logic              mul_en;
    asel_e             a_sel;
    logic              a_hi;
    bsel_e             b_sel;
    accop_e            acc_op;
    logic              store_m;
    logic              shift_hist;
    logic              emit;
  } ctrl_t;

  localparam ctrl_t UC_NOP = '{
    hold_on:    HOLD_NONE,
    jump:       1'b0,
    target:     '0,
    mul_en:     1'b0,
    a_sel:      A_M1,
    a_hi:       1'b0,
    b_sel:      B_S1_FB1,
    acc_op:     ACC_HOLD,
    store_m:    1'b0,
    shift_hist: 1'b0,
    emit:       1'b0
  };

  // Program ROM. A product issued in one step is added in the next one.
  function automatic ctrl_t uc_word(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = UC_NOP;
    unique case (step)
      4'd0: begin
        w.hold_on = HOLD_IN;  w.acc_op = ACC_LOAD1;
        w.mul_en  = 1'b1;     w.a_sel = A_M1; w.a_hi = 1'b0; w.b_sel = B_S1_FB1;
      end
      4'd1: begin
        w.acc_op = ACC_ADD;
        w.mul_en = 1'b1; w.a_sel = A_M1; w.a_hi = 1'b1; w.b_sel = B_S1_FB1;
      end
      4'd2: begin
        w.acc_op = ACC_ADD;
        w.mul_en = 1'b1; w.a_sel = A_M2; w.a_hi = 1'b0; w.b_sel = B_S1_FB2;
      end
      4'd3: begin
        w.acc_op = ACC_ADD;
        w.mul_en = 1'b1; w.a_sel = A_M2; w.a_hi = 1'b1; w.b_sel = B_S1_FB2;
      end
      4'd4: begin
        w.acc_op = ACC_ADD;
      end
      4'd5: begin
        w.store_m = 1'b1; w.acc_op = ACC_LOAD2;
        w.mul_en  = 1'b1; w.a_sel = A_O1; w.a_hi = 1'b0; w.b_sel = B_S2_FB1;
      end
      4'd6: begin
        w.acc_op = ACC_ADD;
        w.mul_en = 1'b1; w.a_sel = A_O1; w.a_hi = 1'b1; w.b_sel = B_S2_FB1;
      end
      4'd7: begin
        w.acc_op = ACC_ADD;
        w.mul_en = 1'b1; w.a_sel = A_O2; w.a_hi = 1'b0; w.b_sel = B_S2_FB2;
      end
      4'd8: begin
        w.acc_op = ACC_ADD;
        w.mul_en = 1'b1; w.a_sel = A_O2; w.a_hi = 1'b1; w.b_sel = B_S2_FB2;
      end
      4'd9: begin
        w.acc_op = ACC_ADD;
      end
      4'd10: begin
        w.shift_hist = 1'b1; w.acc_op = ACC_LOADR;
      end
      4'd11: begin
        w.mul_en = 1'b1; w.a_sel = A_O1; w.a_hi = 1'b0; w.b_sel = B_GAIN;
      end
      4'd12: begin
        w.acc_op = ACC_ADD;
        w.mul_en = 1'b1; w.a_sel = A_O1; w.a_hi = 1'b1; w.b_sel = B_GAIN;
      end
      4'd13: begin
        w.acc_op = ACC_ADD;
      end
      4'd14: begin
        w.hold_on = HOLD_OUT; w.emit = 1'b1;
        w.jump    = 1'b1;     w.target = '0;
      end
      default: begin
        w.jump = 1'b1; w.target = '0;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: design/cbq_stream_if.sv
// Valid/ready channel interfaces for input samples and filtered results.
// Depends on cbq_pkg for the field widths.
`default_nettype none

interface cbq_in_if import cbq_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface cbq_out_if import cbq_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] filtered;
  logic                       saturated;

  modport source (output valid, output filtered, output saturated, input ready);
  modport sink   (input valid, input filtered, input saturated, output ready);
endinterface

`default_nettype wire

// File: design/cbq_apb_regs.sv
// APB configuration registers: feedback coefficients and output gain.
// Depends on cbq_pkg.
`default_nettype none

module cbq_apb_regs import cbq_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready,
  output coef_t                   coef_o
);

  coef_t    coef_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign coef_o = coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.s1_fb1 <= S1_FB1_RST;
      coef_q.s1_fb2 <= S1_FB2_RST;
      coef_q.s2_fb1 <= S2_FB1_RST;
      coef_q.s2_fb2 <= S2_FB2_RST;
      coef_q.gain   <= GAIN_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_S1_FB1: coef_q.s1_fb1 <= pwdata[COEF_W-1:0];
        REG_S1_FB2: coef_q.s1_fb2 <= pwdata[COEF_W-1:0];
        REG_S2_FB1: coef_q.s2_fb1 <= pwdata[COEF_W-1:0];
        REG_S2_FB2: coef_q.s2_fb2 <= pwdata[COEF_W-1:0];
        REG_GAIN:   coef_q.gain   <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // coefficients read back sign-extended
  always_comb begin
    unique case (idx)
      REG_S1_FB1: prdata = {{(DATA_W-COEF_W){coef_q.s1_fb1[COEF_W-1]}}, coef_q.s1_fb1};
      REG_S1_FB2: prdata = {{(DATA_W-COEF_W){coef_q.s1_fb2[COEF_W-1]}}, coef_q.s1_fb2};
      REG_S2_FB1: prdata = {{(DATA_W-COEF_W){coef_q.s2_fb1[COEF_W-1]}}, coef_q.s2_fb1};
      REG_S2_FB2: prdata = {{(DATA_W-COEF_W){coef_q.s2_fb2[COEF_W-1]}}, coef_q.s2_fb2};
      REG_GAIN:   prdata = coef_q.gain;
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: design/cbq_sequencer.sv
// Microcode sequencer: step counter, program ROM lookup, stall and jump logic.
// Depends on cbq_pkg (control word type and program).
`default_nettype none

module cbq_sequencer import cbq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic out_busy_i,
  output ctrl_t     ctrl_o,
  output logic      fire_o,
  output logic      in_ready_o
);

  logic [STEP_W-1:0] step_q, step_d;
  ctrl_t             ctrl;
  logic              stall;

  assign ctrl   = uc_word(step_q);
  assign ctrl_o = ctrl;

  always_comb begin
    unique case (ctrl.hold_on)
      HOLD_IN:  stall = ~in_valid_i;
      HOLD_OUT: stall = out_busy_i;
      default:  stall = 1'b0;
    endcase
  end

  assign fire_o     = ~stall;
  assign in_ready_o = (ctrl.hold_on == HOLD_IN);

  always_comb begin
    if (stall) begin
      step_d = step_q;
    end else if (ctrl.jump) begin
      step_d = ctrl.target;
    end else begin
      step_d = step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_o && ctrl.emit) |=> (step_q == '0))
    else $error("program did not restart after emitting a word");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_o |=> $stable(step_q))
    else $error("step counter moved during a stall");

  a_take_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (step_q == '0))
    else $error("input offered outside the first step");
`endif

endmodule

`default_nettype wire

// File: design/cbq_datapath.sv
// Shared multiply-accumulate datapath with filter history and output register.
// Driven by the control word from cbq_sequencer; depends on cbq_pkg.
`default_nettype none

module cbq_datapath import cbq_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ctrl_t               ctrl_i,
  input  wire logic                fire_i,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  input  wire coef_t               coef_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic      [SAMPLE_W-1:0] filtered_o,
  output logic                     saturated_o,
  output logic                     out_busy_o
);

  logic [SAMPLE_W-1:0] x_q, x1_q, x2_q;
  logic [STATE_W-1:0]  m_q, m1_q, m2_q, o1_q, o2_q;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [P_W-1:0]      prod_q;
  logic signed [P_W-1:0] prod_d;
  logic                prod_hi_q;
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] filtered_q;
  logic                saturated_q;

  logic [STATE_W-1:0]  mul_src;
  logic signed [A_W-1:0] mul_a;
  logic signed [B_W-1:0] mul_b;
  logic [ACC_W-1:0]    prod_ext, add_term;
  logic [N1_W-1:0]     n1;
  logic [N2_W-1:0]     n2;

  logic [ACC_W-STATE_W-FRAC_W:0] st_upper;
  logic                          st_ok;
  logic [STATE_W-1:0]            st_sat;
  logic [ACC_W-OUT_SHIFT-SAMPLE_W:0] out_upper;
  logic                          out_ok;
  logic [SAMPLE_W-1:0]           out_sat;

  logic emit_fire;

  // operand A: one half of a stored state value, low half unsigned
  always_comb begin
    case (ctrl_i.a_sel)
      A_M1:    mul_src = m1_q;
      A_M2:    mul_src = m2_q;
      A_O1:    mul_src = o1_q;
      default: mul_src = o2_q;
    endcase
    if (ctrl_i.a_hi) begin
      mul_a = {mul_src[STATE_W-1], mul_src[STATE_W-1:HALF_W]};
    end else begin
      mul_a = {{(A_W-HALF_W){1'b0}}, mul_src[HALF_W-1:0]};
    end
  end

  always_comb begin
    case (ctrl_i.b_sel)
      B_S1_FB1: mul_b = {{(B_W-COEF_W){coef_i.s1_fb1[COEF_W-1]}}, coef_i.s1_fb1};
      B_S1_FB2: mul_b = {{(B_W-COEF_W){coef_i.s1_fb2[COEF_W-1]}}, coef_i.s1_fb2};
      B_S2_FB1: mul_b = {{(B_W-COEF_W){coef_i.s2_fb1[COEF_W-1]}}, coef_i.s2_fb1};
      B_S2_FB2: mul_b = {{(B_W-COEF_W){coef_i.s2_fb2[COEF_W-1]}}, coef_i.s2_fb2};
      default:  mul_b = {1'b0, coef_i.gain};
    endcase
  end

  assign prod_d = mul_a * mul_b;

  assign prod_ext = {{(ACC_W-P_W){prod_q[P_W-1]}}, prod_q};
  assign add_term = prod_hi_q ? (prod_ext << HALF_W) : prod_ext;

  // numerators 1,2,1
  assign n1 = {{2{sample_i[SAMPLE_W-1]}}, sample_i}
            + {x1_q[SAMPLE_W-1], x1_q, 1'b0}
            + {{2{x2_q[SAMPLE_W-1]}}, x2_q};
  assign n2 = {{2{st_sat[STATE_W-1]}}, st_sat}
            + {m1_q[STATE_W-1], m1_q, 1'b0}
            + {{2{m2_q[STATE_W-1]}}, m2_q};

  // stage result: acc >>> 16 clamped to the state range
  assign st_upper = acc_q[ACC_W-1:STATE_W+FRAC_W-1];
  assign st_ok    = (&st_upper) | ~(|st_upper);
  assign st_sat   = st_ok ? acc_q[STATE_W+FRAC_W-1:FRAC_W]
                          : (acc_q[ACC_W-1] ? STATE_MIN : STATE_MAX);

  // final result: acc >>> 48 clamped to the sample range
  assign out_upper = acc_q[ACC_W-1:OUT_SHIFT+SAMPLE_W-1];
  assign out_ok    = (&out_upper) | ~(|out_upper);
  assign out_sat   = out_ok ? acc_q[OUT_SHIFT+SAMPLE_W-1:OUT_SHIFT]
                            : (acc_q[ACC_W-1] ? OUT_MIN : OUT_MAX);

  always_comb begin
    acc_d = acc_q;
    case (ctrl_i.acc_op)
      ACC_LOAD1: acc_d = {{(ACC_W-N1_W-2*FRAC_W){n1[N1_W-1]}}, n1, {(2*FRAC_W){1'b0}}}
                         | STAGE_RND;
      ACC_LOAD2: acc_d = {{(ACC_W-N2_W-FRAC_W){n2[N2_W-1]}}, n2, {FRAC_W{1'b0}}}
                         | STAGE_RND;
      ACC_LOADR: acc_d = OUT_RND;
      ACC_ADD:   acc_d = acc_q + add_term;
      default:   acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      acc_q <= acc_d;
      if (ctrl_i.mul_en) begin
        prod_q    <= prod_d;
        prod_hi_q <= ctrl_i.a_hi;
      end
      if (ctrl_i.acc_op == ACC_LOAD1) begin
        x_q <= sample_i;
      end
      if (ctrl_i.store_m) begin
        m_q <= st_sat;
      end
    end
  end

  // filter history, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      m1_q <= '0;
      m2_q <= '0;
      o1_q <= '0;
      o2_q <= '0;
    end else if (fire_i && ctrl_i.shift_hist) begin
      x1_q <= x_q;
      x2_q <= x1_q;
      m1_q <= m_q;
      m2_q <= m1_q;
      o1_q <= st_sat;
      o2_q <= o1_q;
    end
  end

  assign emit_fire = fire_i & ctrl_i.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      filtered_q  <= out_sat;
      saturated_q <= ~out_ok;
    end
  end

  assign out_busy_o  = out_valid_q & ~out_ready_i;
  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign saturated_o = saturated_q;

`ifndef SYNTHESIS
  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(emit_fire))
    else $error("result word appeared without an emit step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |-> (!out_valid_q || out_ready_i))
    else $error("pending result word overwritten");

  a_sat_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && saturated_q) |-> (filtered_q == OUT_MAX || filtered_q == OUT_MIN))
    else $error("saturation flag set on an unclipped value");
`endif

endmodule

`default_nettype wire

// File: design/cascaded_biquad_lowpass_core.sv
// Fourth-order low-pass filter: two direct-form-I biquads, gain, round, clip.
// Top level; uses cbq_pkg, cbq_stream_if, cbq_apb_regs, cbq_sequencer, cbq_datapath.
//
// Usage:
//   sample_ch takes one signed 16-bit sample per word (valid/ready).
//   result_ch gives one word per sample: the filtered value, rounded and
//   clipped to 16 bits, and a flag that is set when it was clipped.
//   The APB port holds the four Q2.16 feedback coefficients at 0x00..0x0C and
//   the Q0.32 output gain at 0x10; write them only while the filter is idle.
// Sequencing:
//   A sample's result appears on result_ch once the program has run its
//   emit step; only then does the program return to its first step and
//   accept the next sample. Throughput is set by the single shared 25x33
//   multiplier: ten partial products per sample plus load, clamp and emit steps.
// Reset clears the filter history and the output valid flag and restores the
//   default coefficients and gain.
// A stalled receiver holds the result word; the next sample is still accepted
//   and processed, and the sequencer waits at its last step until the word
//   is taken.
`default_nettype none

module cascaded_biquad_lowpass_core import cbq_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  cbq_in_if.sink                  sample_ch,
  cbq_out_if.source               result_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready
);

  coef_t coef;
  ctrl_t ctrl;
  logic  fire;
  logic  out_busy;
  logic  in_ready;

  cbq_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef)
  );

  cbq_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_ch.valid),
    .out_busy_i (out_busy),
    .ctrl_o     (ctrl),
    .fire_o     (fire),
    .in_ready_o (in_ready)
  );

  assign sample_ch.ready = in_ready;

  cbq_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .fire_i      (fire),
    .sample_i    (sample_ch.sample),
    .coef_i      (coef),
    .out_ready_i (result_ch.ready),
    .out_valid_o (result_ch.valid),
    .filtered_o  (result_ch.filtered),
    .saturated_o (result_ch.saturated),
    .out_busy_o  (out_busy)
  );

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking bench for cascaded_biquad_lowpass_core: random and directed samples,
// APB coefficient sets, a bit-true model of both biquads, gain, rounding and clipping.
// Depends on cbq_pkg and the cbq_in_if / cbq_out_if channel interfaces.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cbq_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 6;
  localparam int LATENCY         = 15;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int WIDE            = 128;

  localparam int DEF_S1_FB1 = 112008;
  localparam int DEF_S1_FB2 = -51957;
  localparam int DEF_S2_FB1 = 97693;
  localparam int DEF_S2_FB2 = -36943;
  localparam int DEF_GAIN   = 1640768;

  localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef logic signed [WIDE-1:0] wide_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       saturated;
  } result_t;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PADDR_W-1:0]  paddr   = '0;
  logic [DATA_W-1:0]   pwdata  = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  cbq_in_if  smp_if ();
  cbq_out_if res_if ();

  cascaded_biquad_lowpass_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_ch (smp_if),
    .result_ch (res_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // filter model state and register shadow
  coef_t                      coef_shadow;
  logic signed [SAMPLE_W-1:0] raw_hist [2];
  logic signed [STATE_W-1:0]  mid_hist [2];
  logic signed [STATE_W-1:0]  out_hist [2];

  logic signed [SAMPLE_W-1:0] sample_q [$];
  result_t                    expected_q [$];

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          idle_on     = 1'b1;
  bit          hold_req    = 1'b0;
  int          src_gap     = 0;
  int          sink_stall  = 0;

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic logic signed [STATE_W-1:0] clamp_state(input wide_t v);
    if (&v[WIDE-1:STATE_W-1] || !(|v[WIDE-1:STATE_W-1])) return v[STATE_W-1:0];
    return v[WIDE-1] ? STATE_MIN : STATE_MAX;
  endfunction

  // num carries 16 fraction bits; the sum is formed with 32, then rounded half up
  function automatic logic signed [STATE_W-1:0] biquad_stage(
    input wide_t                     num,
    input logic signed [STATE_W-1:0] y1,
    input logic signed [STATE_W-1:0] y2,
    input logic signed [COEF_W-1:0]  fb1,
    input logic signed [COEF_W-1:0]  fb2
  );
    wide_t acc, wy1, wy2, wf1, wf2, half_lsb;
    wy1 = y1;
    wy2 = y2;
    wf1 = fb1;
    wf2 = fb2;
    half_lsb = 1;
    acc = (num <<< FRAC_W) + wy1 * wf1 + wy2 * wf2 + (half_lsb <<< (FRAC_W - 1));
    return clamp_state(acc >>> FRAC_W);
  endfunction

  function automatic result_t filter_step(input logic signed [SAMPLE_W-1:0] x);
    wide_t                     wx, wx1, wx2, wm, wm1, wm2, wy, gain_w, half_lsb, scaled;
    logic signed [STATE_W-1:0] m, y;
    result_t                   r;
    wx  = x;
    wx1 = raw_hist[0];
    wx2 = raw_hist[1];
    m = biquad_stage((wx + (wx1 <<< 1) + wx2) <<< FRAC_W, mid_hist[0], mid_hist[1],
                     coef_shadow.s1_fb1, coef_shadow.s1_fb2);
    wm  = m;
    wm1 = mid_hist[0];
    wm2 = mid_hist[1];
    y = biquad_stage(wm + (wm1 <<< 1) + wm2, out_hist[0], out_hist[1],
                     coef_shadow.s2_fb1, coef_shadow.s2_fb2);
    raw_hist[1] = raw_hist[0];
    raw_hist[0] = x;
    mid_hist[1] = mid_hist[0];
    mid_hist[0] = m;
    out_hist[1] = out_hist[0];
    out_hist[0] = y;
    // gain is unsigned Q0.32 on a value with 16 fraction bits
    wy = y;
    gain_w = coef_shadow.gain;
    half_lsb = 1;
    scaled = (wy * gain_w + (half_lsb <<< (FRAC_W + GAIN_W - 1))) >>> (FRAC_W + GAIN_W);
    if (&scaled[WIDE-1:SAMPLE_W-1] || !(|scaled[WIDE-1:SAMPLE_W-1])) begin
      r.filtered  = scaled[SAMPLE_W-1:0];
      r.saturated = 1'b0;
    end else begin
      r.filtered  = scaled[WIDE-1] ? SMP_MIN : SMP_MAX;
      r.saturated = 1'b1;
    end
    return r;
  endfunction

  // sample driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      smp_if.valid <= 1'b0;
    end else begin
      if (smp_if.valid && smp_if.ready) expected_q.push_back(filter_step(smp_if.sample));
      if (!smp_if.valid || smp_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          smp_if.valid <= 1'b0;
        end else if (sample_q.size() == 0) begin
          smp_if.valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(0, 7);
          smp_if.valid <= 1'b0;
        end else begin
          smp_if.valid  <= 1'b1;
          smp_if.sample <= sample_q.pop_front();
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word filtered=%0d saturated=%0b",
                                    res_if.filtered, res_if.saturated));
        end else begin
          want = expected_q.pop_front();
          if (res_if.filtered !== want.filtered)
            report_mismatch($sformatf("filtered got %0d want %0d",
                                      res_if.filtered, want.filtered));
          if (res_if.saturated !== want.saturated)
            report_mismatch($sformatf("saturated got %0b want %0b",
                                      res_if.saturated, want.saturated));
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        res_if.ready <= 1'b0;
      end else if (hold_req) begin
        // long hold-off: the filter has to back up into its input
        hold_req = 1'b0;
        sink_stall = HOLD_OFF_CYCLES - 1;
        res_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        sink_stall = $urandom_range(0, 7);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic reg_write(input logic [REGIDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_S1_FB1: coef_shadow.s1_fb1 = value[COEF_W-1:0];
      REG_S1_FB2: coef_shadow.s1_fb2 = value[COEF_W-1:0];
      REG_S2_FB1: coef_shadow.s2_fb1 = value[COEF_W-1:0];
      REG_S2_FB2: coef_shadow.s2_fb2 = value[COEF_W-1:0];
      REG_GAIN:   coef_shadow.gain   = value[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic reg_read(input logic [REGIDX_W-1:0] idx, output logic [DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // only the register's own bits are compared
  task automatic check_registers();
    logic [DATA_W-1:0] rd, want, mask;
    for (int i = REG_S1_FB1; i <= REG_GAIN; i++) begin
      reg_read(REGIDX_W'(i), rd);
      mask = {{(DATA_W-COEF_W){1'b0}}, {COEF_W{1'b1}}};
      case (i)
        REG_S1_FB1: want = DATA_W'(coef_shadow.s1_fb1);
        REG_S1_FB2: want = DATA_W'(coef_shadow.s1_fb2);
        REG_S2_FB1: want = DATA_W'(coef_shadow.s2_fb1);
        REG_S2_FB2: want = DATA_W'(coef_shadow.s2_fb2);
        default: begin
          want = coef_shadow.gain;
          mask = '1;
        end
      endcase
      if ((rd & mask) !== want)
        report_mismatch($sformatf("register %0d reads %0h want %0h", i, rd & mask, want));
    end
  endtask

  function automatic logic [DATA_W-1:0] coef_word(input logic [COEF_W-1:0] c);
    return {{(DATA_W-COEF_W){c[COEF_W-1]}}, c};
  endfunction

  task automatic load_coefs(input coef_t c);
    reg_write(REG_S1_FB1, coef_word(c.s1_fb1));
    reg_write(REG_S1_FB2, coef_word(c.s1_fb2));
    reg_write(REG_S2_FB1, coef_word(c.s2_fb1));
    reg_write(REG_S2_FB2, coef_word(c.s2_fb2));
    reg_write(REG_GAIN, c.gain);
    check_registers();
  endtask

  function automatic coef_t default_coefs();
    coef_t c;
    c.s1_fb1 = COEF_W'(DEF_S1_FB1);
    c.s1_fb2 = COEF_W'(DEF_S1_FB2);
    c.s2_fb1 = COEF_W'(DEF_S2_FB1);
    c.s2_fb2 = COEF_W'(DEF_S2_FB2);
    c.gain   = GAIN_W'(DEF_GAIN);
    return c;
  endfunction

  task automatic drain();
    while (sample_q.size() != 0 || expected_q.size() != 0 || smp_if.valid)
      @(posedge clk_i);
  endtask

  // with both feedbacks zero, six zero samples empty the whole history
  task automatic clear_history();
    coef_t c;
    drain();
    c = '{s1_fb1: '0, s1_fb2: '0, s2_fb1: '0, s2_fb2: '0, gain: coef_shadow.gain};
    load_coefs(c);
    repeat (6) sample_q.push_back('0);
    drain();
  endtask

  function automatic int jitter(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // mostly held levels so the low-pass output swings full scale and overshoots
  task automatic push_random(input int count);
    int                         left, run, kind, slope;
    logic signed [SAMPLE_W-1:0] level;
    left = count;
    while (left > 0) begin
      kind  = $urandom_range(0, 9);
      run   = (kind < 4) ? $urandom_range(1, 40) : $urandom_range(1, 8);
      run   = (run > left) ? left : run;
      level = SAMPLE_W'($urandom);
      slope = jitter(2000);
      for (int i = 0; i < run; i++) begin
        case (kind)
          0, 1, 2, 3: ;
          4, 5: level = SAMPLE_W'($urandom);
          6: level = SAMPLE_W'(jitter(64));
          7: begin
            case ($urandom_range(0, 3))
              0: level = SMP_MAX;
              1: level = SMP_MIN;
              2: level = '0;
              default: level = '1;
            endcase
          end
          default: level = SAMPLE_W'(level + slope);
        endcase
        sample_q.push_back(level);
      end
      left -= run;
    end
  endtask

  initial begin
    coef_t cfg;
    smp_if.valid  = 1'b0;
    smp_if.sample = '0;
    res_if.ready  = 1'b0;
    coef_shadow = default_coefs();
    raw_hist = '{default: '0};
    mid_hist = '{default: '0};
    out_hist = '{default: '0};
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_registers();

    // reset coefficients: small values, extremes, a full-scale step and its reversal
    sample_q.push_back('0);
    sample_q.push_back(SAMPLE_W'(1));
    sample_q.push_back('1);
    sample_q.push_back(SMP_MAX);
    sample_q.push_back(SMP_MIN);
    repeat (2) sample_q.push_back('0);
    repeat (10) sample_q.push_back(SMP_MAX);
    repeat (8) sample_q.push_back(SMP_MIN);
    drain();
    push_random(150);
    drain();

    // writes past the last register must leave every register alone
    for (int i = int'(REG_GAIN) + 1; i < (1 << REGIDX_W); i++)
      reg_write(REGIDX_W'(i), $urandom);
    check_registers();
    hold_req = 1'b1;
    push_random(100);
    drain();

    // largest feedback: both stages run away into the positive, then the negative state bound
    cfg = '{s1_fb1: COEF_MAX, s1_fb2: COEF_MAX, s2_fb1: COEF_MAX, s2_fb2: COEF_MAX,
            gain: '1};
    load_coefs(cfg);
    repeat (30) sample_q.push_back(SMP_MAX);
    clear_history();
    load_coefs(cfg);
    repeat (30) sample_q.push_back(SMP_MIN);
    clear_history();

    // most negative feedback oscillates while growing; zero gain gives zero words
    cfg = '{s1_fb1: COEF_MIN, s1_fb2: COEF_MIN, s2_fb1: COEF_MIN, s2_fb2: COEF_MIN,
            gain: '0};
    load_coefs(cfg);
    push_random(40);
    clear_history();

    // feedback still zero: plain FIR with a random gain
    reg_write(REG_GAIN, $urandom);
    push_random(100);
    drain();

    repeat (6) begin
      idle_on = ($urandom_range(0, 3) != 0);
      clear_history();
      cfg = default_coefs();
      case ($urandom_range(0, 2))
        0: begin
          cfg.s1_fb1 = COEF_W'(DEF_S1_FB1 + jitter(3000));
          cfg.s1_fb2 = COEF_W'(DEF_S1_FB2 + jitter(3000));
          cfg.s2_fb1 = COEF_W'(DEF_S2_FB1 + jitter(3000));
          cfg.s2_fb2 = COEF_W'(DEF_S2_FB2 + jitter(3000));
          cfg.gain   = $urandom_range(0, 4 * DEF_GAIN);
        end
        1: begin
          cfg.s1_fb1 = COEF_W'($urandom);
          cfg.s1_fb2 = COEF_W'($urandom);
          cfg.s2_fb1 = COEF_W'($urandom);
          cfg.s2_fb2 = COEF_W'($urandom);
          cfg.gain   = $urandom;
        end
        default: cfg.gain = $urandom;
      endcase
      load_coefs(cfg);
      push_random(80);
      drain();
    end

    // back to the reset coefficients, both sides at full rate
    idle_on = 1'b0;
    clear_history();
    load_coefs(default_coefs());
    push_random(150);
    drain();

    repeat (3 * LATENCY) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
design/cbq_pkg.sv
design/cbq_stream_if.sv
design/cbq_apb_regs.sv
design/cbq_sequencer.sv
design/cbq_datapath.sv
design/cascaded_biquad_lowpass_core.sv
verif/tb.sv
